FILE: rtl/dcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcr_pkg: shared types and helpers of the disc contact resolver
// Stage map of the pipeline, the item record that travels through it, and
// the saturation and divider-step helpers.
// ----------------------------------------------------------------------------
package dcr_pkg;

	localparam int NORM_BITS = 28;

	// stage map: index into the pipeline register array
	localparam int K_ENT  = 0;                 // capture, wall step, deltas
	localparam int K_SQR  = 1;                 // squares and masses
	localparam int K_FLG  = 2;                 // overlap test, root init
	localparam int K_SQ0  = 3;                 // first root step
	localparam int SQ_N   = 30;
	localparam int K_DIST = K_SQ0 + SQ_N;      // ceiling root
	localparam int K_DINI = K_DIST + 1;        // normal and split dividers init
	localparam int K_D0   = K_DINI + 1;
	localparam int DN     = 29;
	localparam int K_PRD  = K_D0 + DN;         // position and dot products
	localparam int K_POS  = K_PRD + 1;         // position results, dot
	localparam int K_FINI = K_POS + 1;         // impulse dividers init
	localparam int K_F0   = K_FINI + 1;
	localparam int FN     = 35;
	localparam int K_VPR  = K_F0 + FN;         // impulse products
	localparam int K_VEL  = K_VPR + 1;         // velocity results
	localparam int NST    = K_VEL + 1;

	// result slots
	localparam int R_AX  = 0;
	localparam int R_AY  = 1;
	localparam int R_AVX = 2;
	localparam int R_AVY = 3;
	localparam int R_BX  = 4;
	localparam int R_BY  = 5;
	localparam int R_BVX = 6;
	localparam int R_BVY = 7;

	typedef struct packed {
		logic               op;
		logic               touched;
		logic [7:0][31:0]   res;
		logic [7:0]         ra;
		logic [7:0]         rb;
		logic [28:0]        rs;
		logic               inr;
		logic               sgx;
		logic               sgy;
		logic [28:0]        mx;
		logic [28:0]        my;
		logic [58:0]        d2;
		logic [57:0]        rs2;
		logic [15:0]        ma;
		logic [15:0]        mb;
		logic [16:0]        m;
		logic               ovl;
		logic               near;
		logic [59:0]        sq_rad;
		logic [31:0]        sq_rem;
		logic [29:0]        sq_root;
		logic [29:0]        cdist;
		logic [3:0][31:0]   dv_rem;
		logic [3:0][28:0]   dv_bits;
		logic [3:0][28:0]   dv_q;
		logic [28:0]        nxm;
		logic [28:0]        nym;
		logic               sx;
		logic               sy;
		logic [3:0][57:0]   pm;
		logic [62:0]        px;
		logic [62:0]        py;
		logic               ppos;
		logic [33:0]        dot;
		logic [1:0][31:0]   fv_rem;
		logic [1:0][34:0]   fv_bits;
		logic [1:0][34:0]   fv_q;
		logic [3:0][63:0]   vm;
	} item_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// one restoring step: shift in one numerator bit, subtract when it fits
	function automatic logic [32:0] div_step(input logic [31:0] rem, input logic [31:0] den,
		input logic b);
		logic [31:0] t;
		t = {rem[30:0], b};
		if (t >= den) begin
			return {1'b1, t - den};
		end
		return {1'b0, t};
	endfunction

endpackage
`default_nettype wire

FILE: rtl/dcr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcr_ifs: item and result channels of the disc contact resolver
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dcr_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] a_pos_x;
	logic [31:0] a_pos_y;
	logic [31:0] a_vel_x;
	logic [31:0] a_vel_y;
	logic [7:0]  a_radius;
	logic [31:0] b_pos_x;
	logic [31:0] b_pos_y;
	logic [31:0] b_vel_x;
	logic [31:0] b_vel_y;
	logic [7:0]  b_radius;

	modport source (output valid, op, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius,
		b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, input ready);
	modport sink (input valid, op, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius,
		b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, output ready);
endinterface

interface dcr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_a_pos_x;
	logic [31:0] new_a_pos_y;
	logic [31:0] new_a_vel_x;
	logic [31:0] new_a_vel_y;
	logic [31:0] new_b_pos_x;
	logic [31:0] new_b_pos_y;
	logic [31:0] new_b_vel_x;
	logic [31:0] new_b_vel_y;
	logic        touched;

	modport source (output valid, new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
		new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y, touched, input ready);
	modport sink (input valid, new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
		new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y, touched, output ready);
endinterface
`default_nettype wire

FILE: rtl/disc_contact_resolver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// disc_contact_resolver_core: wall and pair contact step for two discs
// Fixed-point wall clamp/reflect and mass-weighted pair separation with an
// elastic velocity exchange; a deep pipeline takes one beat per cycle when not stalled.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while the output is not stalled and
// returns one result beat per input beat, in order. The pipeline depth comes from the
// serial arithmetic: a 30-step digit-by-digit square root for the centre
// distance, a 29-step restoring divider bank for the normal and the mass split,
// and a 35-step divider bank for the impulse; every step is its own pipeline
// stage. When the result beat at the output is not taken, the whole pipeline
// holds and req.ready drops; nothing is lost or repeated. Screen width and
// height are written on the wr_* port; the user must do so only while the block
// is idle, and the block does not enforce this. A write takes effect for the next beat.
module disc_contact_resolver_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic [15:0] wr_data,
	dcr_in_if.sink           req,
	dcr_out_if.source        rsp
);

	localparam int G    = (FRAC_BITS > 20) ? 20 : FRAC_BITS;   // geometry fraction bits
	localparam int DROP = FRAC_BITS - G;
	// d2 * 10^8 < 2^(2G)  <=>  d2 < ceil(2^(2G) / 10^8)
	localparam logic [63:0] NEAR_LIM = ((64'd1 << (2 * G)) + 64'd99999999) / 64'd100000000;
	localparam int LAST = dcr_pkg::NST - 1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	logic [15:0] scr_w_q;
	logic [15:0] scr_h_q;

	dcr_pkg::item_t pipe_s [dcr_pkg::NST];
	logic           vld_q  [dcr_pkg::NST];
	dcr_pkg::item_t nxt    [dcr_pkg::NST];
	dcr_pkg::item_t ent;
	logic           en;

	// entry stage temporaries
	logic signed [42:0] w_r, w_w, w_h, w_px, w_py;
	logic               hit_x, hit_y;
	logic signed [32:0] dx, dy;
	logic [32:0]        magx, magy, mx33, my33;
	logic [28:0]        rsum;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= 16'd800;
			scr_h_q <= 16'd600;
		end else if (wr_en) begin
			case (wr_index)
				REG_WIDTH:  scr_w_q <= wr_data;
				REG_HEIGHT: scr_h_q <= wr_data;
				default:    scr_w_q <= scr_w_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// one pipeline stage; k picks the work done at that stage
	// ------------------------------------------------------------------
	function automatic dcr_pkg::item_t stage_step(input int k, input dcr_pkg::item_t x);
		dcr_pkg::item_t     y;
		logic [33:0]        t, tr;
		logic [32:0]        ds;
		logic [31:0]        den;
		logic [28:0]        ov;
		logic [44:0]        na, nb;
		logic [50:0]        fa, fb;
		logic signed [29:0] nxs, nys;
		logic signed [32:0] dvx, dvy;
		logic signed [63:0] sh, p;
		y = x;
		if (k == dcr_pkg::K_SQR) begin
			y.d2  = 59'(58'(x.mx) * 58'(x.mx)) + 59'(58'(x.my) * 58'(x.my));
			y.rs2 = 58'(x.rs) * 58'(x.rs);
			y.ma  = 16'(x.ra) * 16'(x.ra);
			y.mb  = 16'(x.rb) * 16'(x.rb);
			y.m   = 17'(16'(x.ra) * 16'(x.ra)) + 17'(16'(x.rb) * 16'(x.rb));
		end else if (k == dcr_pkg::K_FLG) begin
			y.ovl     = x.op && x.inr && (x.d2 < {1'b0, x.rs2});
			y.near    = y.ovl && (64'(x.d2) < NEAR_LIM);
			y.touched = x.touched | y.ovl;
			y.sq_rad  = {1'b0, x.d2};
			y.sq_rem  = '0;
			y.sq_root = '0;
		end else if (k >= dcr_pkg::K_SQ0 && k < dcr_pkg::K_DIST) begin
			// bring down two bits, try root*4+1
			t  = {x.sq_rem, x.sq_rad[59:58]};
			tr = {2'b00, x.sq_root, 2'b01};
			if (t >= tr) begin
				y.sq_rem  = 32'(t - tr);
				y.sq_root = {x.sq_root[28:0], 1'b1};
			end else begin
				y.sq_rem  = t[31:0];
				y.sq_root = {x.sq_root[28:0], 1'b0};
			end
			y.sq_rad = {x.sq_rad[57:0], 2'b00};
		end else if (k == dcr_pkg::K_DIST) begin
			y.cdist = x.near ? (30'd1 << G) : x.sq_root + 30'(x.sq_rem != 32'd0);
		end else if (k == dcr_pkg::K_DINI) begin
			ov = 29'({1'b0, x.rs} - x.cdist);
			na = 45'(ov) * 45'(x.mb);
			nb = 45'(ov) * 45'(x.ma);
			// numerators |g| * 2^28 and ov * mass, fed one bit per step
			y.dv_rem[0]  = 32'(x.mx[28:1]);
			y.dv_bits[0] = {x.mx[0], 28'd0};
			y.dv_rem[1]  = 32'(x.my[28:1]);
			y.dv_bits[1] = {x.my[0], 28'd0};
			y.dv_rem[2]  = 32'(na[44:29]);
			y.dv_bits[2] = na[28:0];
			y.dv_rem[3]  = 32'(nb[44:29]);
			y.dv_bits[3] = nb[28:0];
			y.dv_q       = '0;
		end else if (k >= dcr_pkg::K_D0 && k < dcr_pkg::K_PRD) begin
			for (int j = 0; j < 4; j++) begin
				den = (j < 2) ? 32'(x.cdist) : 32'(x.m);
				ds  = dcr_pkg::div_step(x.dv_rem[j], den, x.dv_bits[j][28]);
				y.dv_rem[j]  = ds[31:0];
				y.dv_q[j]    = {x.dv_q[j][27:0], ds[32]};
				y.dv_bits[j] = {x.dv_bits[j][27:0], 1'b0};
			end
		end else if (k == dcr_pkg::K_PRD) begin
			y.nxm = x.near ? 29'(1 << dcr_pkg::NORM_BITS) : x.dv_q[0];
			y.nym = x.near ? 29'd0 : x.dv_q[1];
			y.sx  = !x.near && x.sgx;
			y.sy  = !x.near && x.sgy;
			y.pm[0] = 58'(y.nxm) * 58'(x.dv_q[2]);
			y.pm[1] = 58'(y.nym) * 58'(x.dv_q[2]);
			y.pm[2] = 58'(y.nxm) * 58'(x.dv_q[3]);
			y.pm[3] = 58'(y.nym) * 58'(x.dv_q[3]);
			nxs = y.sx ? -$signed({1'b0, y.nxm}) : $signed({1'b0, y.nxm});
			nys = y.sy ? -$signed({1'b0, y.nym}) : $signed({1'b0, y.nym});
			dvx = 33'($signed(x.res[dcr_pkg::R_AVX])) - 33'($signed(x.res[dcr_pkg::R_BVX]));
			dvy = 33'($signed(x.res[dcr_pkg::R_AVY])) - 33'($signed(x.res[dcr_pkg::R_BVY]));
			y.px = 63'(63'(nxs) * 63'(dvx));
			y.py = 63'(63'(nys) * 63'(dvy));
		end else if (k == dcr_pkg::K_POS) begin
			if (x.ovl) begin
				sh = 64'(x.pm[0][57:28]) << DROP;
				y.res[dcr_pkg::R_AX] = dcr_pkg::sat32(64'($signed(x.res[dcr_pkg::R_AX]))
					- (x.sx ? -sh : sh));
				sh = 64'(x.pm[1][57:28]) << DROP;
				y.res[dcr_pkg::R_AY] = dcr_pkg::sat32(64'($signed(x.res[dcr_pkg::R_AY]))
					- (x.sy ? -sh : sh));
				sh = 64'(x.pm[2][57:28]) << DROP;
				y.res[dcr_pkg::R_BX] = dcr_pkg::sat32(64'($signed(x.res[dcr_pkg::R_BX]))
					+ (x.sx ? -sh : sh));
				sh = 64'(x.pm[3][57:28]) << DROP;
				y.res[dcr_pkg::R_BY] = dcr_pkg::sat32(64'($signed(x.res[dcr_pkg::R_BY]))
					+ (x.sy ? -sh : sh));
			end
			p      = 64'($signed(x.px)) + 64'($signed(x.py));
			y.ppos = x.ovl && (p > 64'sd0);
			y.dot  = p[61:28];
		end else if (k == dcr_pkg::K_FINI) begin
			fa = 51'({x.mb, 1'b0}) * 51'(x.dot);
			fb = 51'({x.ma, 1'b0}) * 51'(x.dot);
			y.fv_rem[0]  = 32'(fa[50:35]);
			y.fv_bits[0] = fa[34:0];
			y.fv_rem[1]  = 32'(fb[50:35]);
			y.fv_bits[1] = fb[34:0];
			y.fv_q       = '0;
		end else if (k >= dcr_pkg::K_F0 && k < dcr_pkg::K_VPR) begin
			for (int j = 0; j < 2; j++) begin
				ds = dcr_pkg::div_step(x.fv_rem[j], 32'(x.m), x.fv_bits[j][34]);
				y.fv_rem[j]  = ds[31:0];
				y.fv_q[j]    = {x.fv_q[j][33:0], ds[32]};
				y.fv_bits[j] = {x.fv_bits[j][33:0], 1'b0};
			end
		end else if (k == dcr_pkg::K_VPR) begin
			y.vm[0] = 64'(x.fv_q[0]) * 64'(x.nxm);
			y.vm[1] = 64'(x.fv_q[0]) * 64'(x.nym);
			y.vm[2] = 64'(x.fv_q[1]) * 64'(x.nxm);
			y.vm[3] = 64'(x.fv_q[1]) * 64'(x.nym);
		end else if (k == dcr_pkg::K_VEL) begin
			if (x.ppos) begin
				sh = 64'(x.vm[0][63:28]);
				y.res[dcr_pkg::R_AVX] = dcr_pkg::sat32(64'($signed(x.res[dcr_pkg::R_AVX]))
					- (x.sx ? -sh : sh));
				sh = 64'(x.vm[1][63:28]);
				y.res[dcr_pkg::R_AVY] = dcr_pkg::sat32(64'($signed(x.res[dcr_pkg::R_AVY]))
					- (x.sy ? -sh : sh));
				sh = 64'(x.vm[2][63:28]);
				y.res[dcr_pkg::R_BVX] = dcr_pkg::sat32(64'($signed(x.res[dcr_pkg::R_BVX]))
					+ (x.sx ? -sh : sh));
				sh = 64'(x.vm[3][63:28]);
				y.res[dcr_pkg::R_BVY] = dcr_pkg::sat32(64'($signed(x.res[dcr_pkg::R_BVY]))
					+ (x.sy ? -sh : sh));
			end
		end
		return y;
	endfunction

	// ------------------------------------------------------------------
	// entry stage: wall step in full, centre deltas for the pair step
	// ------------------------------------------------------------------
	always_comb begin
		ent = '0;
		ent.op = req.op;
		ent.ra = req.a_radius;
		ent.rb = req.b_radius;
		ent.res[dcr_pkg::R_AX]  = req.a_pos_x;
		ent.res[dcr_pkg::R_AY]  = req.a_pos_y;
		ent.res[dcr_pkg::R_AVX] = req.a_vel_x;
		ent.res[dcr_pkg::R_AVY] = req.a_vel_y;
		ent.res[dcr_pkg::R_BX]  = req.b_pos_x;
		ent.res[dcr_pkg::R_BY]  = req.b_pos_y;
		ent.res[dcr_pkg::R_BVX] = req.b_vel_x;
		ent.res[dcr_pkg::R_BVY] = req.b_vel_y;

		// walls: right before left, bottom before top
		w_r  = 43'(req.a_radius) << FRAC_BITS;
		w_w  = 43'(scr_w_q) << FRAC_BITS;
		w_h  = 43'(scr_h_q) << FRAC_BITS;
		w_px = 43'($signed(req.a_pos_x));
		w_py = 43'($signed(req.a_pos_y));
		hit_x = 1'b1;
		if (w_px + w_r > w_w) begin
			w_px = w_w - w_r;
		end else if (w_px - w_r < 43'sd0) begin
			w_px = w_r;
		end else begin
			hit_x = 1'b0;
		end
		hit_y = 1'b1;
		if (w_py + w_r > w_h) begin
			w_py = w_h - w_r;
		end else if (w_py - w_r < 43'sd0) begin
			w_py = w_r;
		end else begin
			hit_y = 1'b0;
		end
		if (!req.op) begin
			ent.touched = hit_x | hit_y;
			ent.res[dcr_pkg::R_AX] = dcr_pkg::sat32(64'(w_px));
			ent.res[dcr_pkg::R_AY] = dcr_pkg::sat32(64'(w_py));
			if (hit_x) begin
				ent.res[dcr_pkg::R_AVX] = dcr_pkg::sat32(-64'($signed(req.a_vel_x)));
			end
			if (hit_y) begin
				ent.res[dcr_pkg::R_AVY] = dcr_pkg::sat32(-64'($signed(req.a_vel_y)));
			end
		end

		// pair deltas, truncated to the geometry format
		dx   = 33'($signed(req.b_pos_x)) - 33'($signed(req.a_pos_x));
		dy   = 33'($signed(req.b_pos_y)) - 33'($signed(req.a_pos_y));
		magx = dx[32] ? 33'(-dx) : 33'(dx);
		magy = dy[32] ? 33'(-dy) : 33'(dy);
		mx33 = magx >> DROP;
		my33 = magy >> DROP;
		rsum = 29'(9'(req.a_radius) + 9'(req.b_radius)) << G;
		ent.rs  = rsum;
		ent.inr = (mx33 < 33'(rsum)) && (my33 < 33'(rsum));
		ent.mx  = mx33[28:0];
		ent.my  = my33[28:0];
		ent.sgx = dx[32];
		ent.sgy = dy[32];
	end

	always_comb begin
		nxt[0] = ent;
		for (int k = 1; k < dcr_pkg::NST; k++) begin
			nxt[k] = stage_step(k, pipe_s[k - 1]);
		end
	end

	// ------------------------------------------------------------------
	// pipeline: advance everything together, hold all on output stall
	// ------------------------------------------------------------------
	assign en        = !vld_q[LAST] || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < dcr_pkg::NST; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= req.valid;
			for (int k = 1; k < dcr_pkg::NST; k++) begin
				vld_q[k] <= vld_q[k - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < dcr_pkg::NST; k++) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	assign rsp.valid       = vld_q[LAST];
	assign rsp.new_a_pos_x = pipe_s[LAST].res[dcr_pkg::R_AX];
	assign rsp.new_a_pos_y = pipe_s[LAST].res[dcr_pkg::R_AY];
	assign rsp.new_a_vel_x = pipe_s[LAST].res[dcr_pkg::R_AVX];
	assign rsp.new_a_vel_y = pipe_s[LAST].res[dcr_pkg::R_AVY];
	assign rsp.new_b_pos_x = pipe_s[LAST].res[dcr_pkg::R_BX];
	assign rsp.new_b_pos_y = pipe_s[LAST].res[dcr_pkg::R_BY];
	assign rsp.new_b_vel_x = pipe_s[LAST].res[dcr_pkg::R_BVX];
	assign rsp.new_b_vel_y = pipe_s[LAST].res[dcr_pkg::R_BVY];
	assign rsp.touched     = pipe_s[LAST].touched;

`ifndef NO_ASSERTIONS
	// floor root never overshoots the squared distance
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[dcr_pkg::K_DIST - 1] && pipe_s[dcr_pkg::K_DIST - 1].ovl |->
		60'(pipe_s[dcr_pkg::K_DIST - 1].sq_root) * 60'(pipe_s[dcr_pkg::K_DIST - 1].sq_root)
		<= 60'(pipe_s[dcr_pkg::K_DIST - 1].d2))
		else $error("square root above its operand");

	// overlapping discs are never farther apart than their radius sum
	a_dist_in_reach: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[dcr_pkg::K_DIST] && pipe_s[dcr_pkg::K_DIST].ovl |->
		{1'b0, pipe_s[dcr_pkg::K_DIST].rs} >= pipe_s[dcr_pkg::K_DIST].cdist)
		else $error("contact distance beyond radius sum");

	// a normal component is at most one in magnitude
	a_unit_normal: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[dcr_pkg::K_PRD - 1] && pipe_s[dcr_pkg::K_PRD - 1].ovl &&
		!pipe_s[dcr_pkg::K_PRD - 1].near |->
		pipe_s[dcr_pkg::K_PRD - 1].dv_q[0] <= 29'(1 << dcr_pkg::NORM_BITS) &&
		pipe_s[dcr_pkg::K_PRD - 1].dv_q[1] <= 29'(1 << dcr_pkg::NORM_BITS))
		else $error("normal component above one");
`endif

endmodule
`default_nettype wire

FILE: dv/disc_contact_resolver_core_tb.sv
// ----------------------------------------------------------------------------
// disc_contact_resolver_core_tb: self-checking bench for the disc contact step
// Drives wall and pair beats under random bursts, stalls and long back-pressure,
// and compares every result beat against hand-written values or a bit-exact
// fixed-point predictor. The screen size is stepped through several settings, extremes included.
// ----------------------------------------------------------------------------
module disc_contact_resolver_core_tb;

	localparam int FRAC = 16;
	localparam int GEO = (FRAC > 20) ? 20 : FRAC;
	localparam int DROP = FRAC - GEO;
	localparam longint unsigned NORM_ONE = 64'd1 << dcr_pkg::NORM_BITS;
	localparam int DRAIN_CYCLES = 130;       // a little beyond the pipeline depth
	localparam int LONG_HOLD = 400;          // longer than the pipeline is deep

	localparam logic OP_WALL = 1'b0;
	localparam logic OP_PAIR = 1'b1;
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// k[]: a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y
	typedef struct {
		logic        op;
		logic [31:0] k[8];
		logic [7:0]  ra;
		logic [7:0]  rb;
	} disc_beat_t;

	typedef struct {
		logic [31:0] v[8];
		logic        touched;
	} contact_res_t;

	typedef struct {
		disc_beat_t   beat;
		bit           typed;
		contact_res_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic wr_index;
	logic [15:0] wr_data;

	dcr_in_if req();
	dcr_out_if rsp();

	disc_contact_resolver_core #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .req(req.sink), .rsp(rsp.source)
	);

	// predictor copy of the screen registers
	logic [15:0] screen_w;
	logic [15:0] screen_h;

	contact_res_t pending_results[$];
	int errors;
	int beats_sent;
	int beats_checked;
	int touch_count;
	int pair_count;
	bit long_hold_req;

	string field_name[8] = '{"new_a_pos_x", "new_a_pos_y", "new_a_vel_x", "new_a_vel_y",
		"new_b_pos_x", "new_b_pos_y", "new_b_vel_x", "new_b_vel_y"};

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ------------------------------------------------------------------
	// fixed-point predictor
	// ------------------------------------------------------------------
	function automatic logic [31:0] clip32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// divide, rounding toward zero, by a positive divisor
	function automatic longint quot_tz(longint num, longint unsigned den);
		longint unsigned mag;
		mag = (num < 0) ? (64'd0 - 64'(num)) : 64'(num);
		mag = mag / den;
		return (num < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint unsigned root_ceil(longint unsigned v);
		longint unsigned root, bitv, rem;
		root = 0;
		bitv = 64'd1 << 62;
		rem = v;
		while (bitv > rem) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return (root * root < v) ? root + 1 : root;
	endfunction

	// clamp one axis against [0, lim], reflect the velocity on a hit
	function automatic bit fold_wall(ref longint p, ref longint v, input longint r,
		input longint lim);
		if (p + r > lim) begin
			p = lim - r;
		end else if (p - r < 0) begin
			p = r;
		end else begin
			return 1'b0;
		end
		v = -v;
		return 1'b1;
	endfunction

	function automatic contact_res_t resolve_contact(disc_beat_t b, logic [15:0] w,
		logic [15:0] h);
		contact_res_t o;
		longint d[8];
		longint r, dx, dy, gx, gy, nx, ny, ov, sa, sb, p, fa, fb, up;
		longint unsigned mx, my, rs, d2, cdist, ma, mb, m, dot;
		bit hit;
		hit = 1'b0;
		for (int i = 0; i < 8; i++) d[i] = longint'($signed(b.k[i]));
		if (b.op == OP_WALL) begin
			r = longint'(b.ra) << FRAC;
			hit = fold_wall(d[0], d[2], r, longint'(w) << FRAC);
			hit = fold_wall(d[1], d[3], r, longint'(h) << FRAC) | hit;
		end else begin
			dx = d[4] - d[0];
			dy = d[5] - d[1];
			mx = ((dx < 0) ? 64'd0 - 64'(dx) : 64'(dx)) >> DROP;
			my = ((dy < 0) ? 64'd0 - 64'(dy) : 64'(dy)) >> DROP;
			rs = (64'(b.ra) + 64'(b.rb)) << GEO;
			// guard the squares against overflow before forming them
			if (mx < rs && my < rs) begin
				d2 = mx * mx + my * my;
				if (d2 < rs * rs) begin
					hit = 1'b1;
					gx = (dx < 0) ? -longint'(mx) : longint'(mx);
					gy = (dy < 0) ? -longint'(my) : longint'(my);
					ma = 64'(b.ra) * 64'(b.ra);
					mb = 64'(b.rb) * 64'(b.rb);
					m = ma + mb;
					up = longint'(1) << DROP;
					if (d2 < (64'd1 << 34) && d2 * 64'd100000000 < (64'd1 << (2 * GEO))) begin
						nx = longint'(NORM_ONE);
						ny = 0;
						cdist = 64'd1 << GEO;
					end else begin
						cdist = root_ceil(d2);
						nx = quot_tz(gx * longint'(NORM_ONE), cdist);
						ny = quot_tz(gy * longint'(NORM_ONE), cdist);
					end
					ov = longint'(rs) - longint'(cdist);
					sa = longint'((64'(ov) * mb) / m);
					sb = longint'((64'(ov) * ma) / m);
					d[0] = d[0] - quot_tz(nx * sa, NORM_ONE) * up;
					d[1] = d[1] - quot_tz(ny * sa, NORM_ONE) * up;
					d[4] = d[4] + quot_tz(nx * sb, NORM_ONE) * up;
					d[5] = d[5] + quot_tz(ny * sb, NORM_ONE) * up;
					p = nx * (d[2] - d[6]) + ny * (d[3] - d[7]);
					// exchange momentum only while the discs approach
					if (p > 0) begin
						dot = 64'(p) >> dcr_pkg::NORM_BITS;
						fa = longint'((64'd2 * mb * dot) / m);
						fb = longint'((64'd2 * ma * dot) / m);
						d[2] = d[2] - quot_tz(fa * nx, NORM_ONE);
						d[3] = d[3] - quot_tz(fa * ny, NORM_ONE);
						d[6] = d[6] + quot_tz(fb * nx, NORM_ONE);
						d[7] = d[7] + quot_tz(fb * ny, NORM_ONE);
					end
				end
			end
		end
		for (int i = 0; i < 8; i++) o.v[i] = clip32(d[i]);
		o.touched = hit;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic disc_beat_t mk_beat(logic op, int apx, int apy, int avx, int avy,
		int ra, int bpx, int bpy, int bvx, int bvy, int rb);
		disc_beat_t b;
		b.op = op;
		b.k = '{apx, apy, avx, avy, bpx, bpy, bvx, bvy};
		b.ra = 8'(ra);
		b.rb = 8'(rb);
		return b;
	endfunction

	function automatic contact_res_t mk_res(int apx, int apy, int avx, int avy, int bpx,
		int bpy, int bvx, int bvy, logic touched);
		contact_res_t o;
		o.v = '{apx, apy, avx, avy, bpx, bpy, bvx, bvy};
		o.touched = touched;
		return o;
	endfunction

	function automatic int signed_span(int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	function automatic disc_beat_t random_beat(logic [15:0] w, logic [15:0] h);
		disc_beat_t b;
		int kind, reach, sep;
		kind = $urandom_range(0, 9);
		b.ra = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
			: 8'($urandom_range(1, 40));
		b.rb = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
			: 8'($urandom_range(1, 40));
		for (int i = 0; i < 8; i++) b.k[i] = $urandom;
		if (kind < 2) begin
			// noise: op and every position and velocity field fully random
			b.op = 1'($urandom_range(0, 1));
		end else if (kind < 5) begin
			// wall step with the disc straddling or near an edge
			b.op = OP_WALL;
			b.k[0] = ($urandom_range(0, 32'(w) + 300) << FRAC) + $urandom_range(0, 65535)
				- (300 << FRAC);
			b.k[1] = ($urandom_range(0, 32'(h) + 300) << FRAC) + $urandom_range(0, 65535)
				- (300 << FRAC);
			b.k[2] = signed_span(1 << 24);
			b.k[3] = signed_span(1 << 24);
		end else begin
			// pair step with B placed around A, mostly within touching range
			b.op = OP_PAIR;
			reach = (int'(b.ra) + int'(b.rb)) * 5 / 4;
			b.k[0] = ($urandom_range(0, 32'(w)) << FRAC) + $urandom_range(0, 65535);
			b.k[1] = ($urandom_range(0, 32'(h)) << FRAC) + $urandom_range(0, 65535);
			sep = $urandom_range(0, 15);
			if (sep == 0) begin
				b.k[4] = b.k[0];
				b.k[5] = b.k[1] + $urandom_range(0, 3);
			end else begin
				b.k[4] = b.k[0] + signed_span(reach << FRAC);
				b.k[5] = b.k[1] + signed_span(reach << FRAC);
			end
			if (sep != 1) begin
				for (int i = 2; i < 8; i += ((i == 3) ? 3 : 1)) begin
					b.k[i] = signed_span(1 << 26);
				end
			end
		end
		return b;
	endfunction

	// ------------------------------------------------------------------
	// sender side: bursts of beats with random gaps
	// ------------------------------------------------------------------
	int burst_left;

	task automatic send_beat(disc_beat_t b, bit typed, contact_res_t typed_res);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req.valid = 1'b1;
		req.op = b.op;
		req.a_pos_x = b.k[0];
		req.a_pos_y = b.k[1];
		req.a_vel_x = b.k[2];
		req.a_vel_y = b.k[3];
		req.a_radius = b.ra;
		req.b_pos_x = b.k[4];
		req.b_pos_y = b.k[5];
		req.b_vel_x = b.k[6];
		req.b_vel_y = b.k[7];
		req.b_radius = b.rb;
		// hold the beat until the block takes it
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(typed ? typed_res : resolve_contact(b, screen_w, screen_h));
		beats_sent++;
		if (b.op == OP_PAIR) pair_count++;
		@(negedge clk);
	endtask

	// pause the sender and let the pipeline run dry
	task automatic drain_pipeline();
		req.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_screen(logic [15:0] w, logic [15:0] h);
		wr_en = 1'b1;
		wr_index = REG_WIDTH;
		wr_data = w;
		@(negedge clk);
		wr_index = REG_HEIGHT;
		wr_data = h;
		@(negedge clk);
		wr_en = 1'b0;
		screen_w = w;
		screen_h = h;
	endtask

	// ------------------------------------------------------------------
	// receiver side: own stall pattern plus one long hold-off
	// ------------------------------------------------------------------
	initial begin
		int mode, left, tick;
		rsp.ready = 1'b0;
		mode = 0;
		left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (long_hold_req) begin
				// hold off long enough for the block to back up into its input
				rsp.ready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold_req = 1'b0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 96);
			end
			left--;
			case (mode)
				0: rsp.ready = 1'b1;
				1: rsp.ready = ($urandom_range(0, 1) == 1);
				2: rsp.ready = (tick % 5 != 0);
				default: rsp.ready = ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	function automatic void report(int idx, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s expected %h got %h (result %0d)", $time, field_name[idx],
			want, got, beats_checked);
		errors++;
	endfunction

	always @(posedge clk) begin
		contact_res_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.new_a_pos_x !== want.v[0]) report(0, want.v[0], rsp.new_a_pos_x);
				if (rsp.new_a_pos_y !== want.v[1]) report(1, want.v[1], rsp.new_a_pos_y);
				if (rsp.new_a_vel_x !== want.v[2]) report(2, want.v[2], rsp.new_a_vel_x);
				if (rsp.new_a_vel_y !== want.v[3]) report(3, want.v[3], rsp.new_a_vel_y);
				if (rsp.new_b_pos_x !== want.v[4]) report(4, want.v[4], rsp.new_b_pos_x);
				if (rsp.new_b_pos_y !== want.v[5]) report(5, want.v[5], rsp.new_b_pos_y);
				if (rsp.new_b_vel_x !== want.v[6]) report(6, want.v[6], rsp.new_b_vel_x);
				if (rsp.new_b_vel_y !== want.v[7]) report(7, want.v[7], rsp.new_b_vel_y);
				if (rsp.touched !== want.touched) begin
					$display("%0t: touched expected %0b got %0b", $time, want.touched,
						rsp.touched);
					errors++;
				end
				beats_checked++;
				if (want.touched) touch_count++;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------
	initial begin
		#(64'd12 * 64'd3_000_000);
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		stim_row_t rows[$];
		contact_res_t none;
		logic [15:0] setting_w[4];
		logic [15:0] setting_h[4];
		int per_phase;
		none = mk_res(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		errors = 0;
		beats_sent = 0;
		beats_checked = 0;
		touch_count = 0;
		pair_count = 0;
		burst_left = 0;
		long_hold_req = 1'b0;
		screen_w = 16'd800;
		screen_h = 16'd600;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_WIDTH;
		wr_data = '0;
		req.valid = 1'b0;
		req.op = OP_WALL;
		req.a_pos_x = '0;
		req.a_pos_y = '0;
		req.a_vel_x = '0;
		req.a_vel_y = '0;
		req.a_radius = 8'd1;
		req.b_pos_x = '0;
		req.b_pos_y = '0;
		req.b_vel_x = '0;
		req.b_vel_y = '0;
		req.b_radius = 8'd1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows at the reset screen of 800 by 600
		// inside the screen: nothing moves
		rows.push_back('{mk_beat(OP_WALL, 100 << 16, 100 << 16, 7, -7, 10, 1, 2, 3, 4, 5),
			1, mk_res(100 << 16, 100 << 16, 7, -7, 1, 2, 3, 4, 1'b0)});
		// right wall, then bottom wall: clamp to the edge minus radius, reflect
		rows.push_back('{mk_beat(OP_WALL, 799 << 16, 300 << 16, 5 << 16, 9, 10, 0, 0, 0, 0, 1),
			1, mk_res(790 << 16, 300 << 16, -(5 << 16), 9, 0, 0, 0, 0, 1'b1)});
		rows.push_back('{mk_beat(OP_WALL, 400 << 16, 599 << 16, 3, 1 << 20, 10, 0, 0, 0, 0, 1),
			1, mk_res(400 << 16, 590 << 16, 3, -(1 << 20), 0, 0, 0, 0, 1'b1)});
		// left and top walls together: clamp to the radius on both axes
		rows.push_back('{mk_beat(OP_WALL, 0, 2 << 16, -4, -8, 5, 0, 0, 0, 0, 255),
			1, mk_res(5 << 16, 5 << 16, 4, 8, 0, 0, 0, 0, 1'b1)});
		// most negative velocity reflects to the largest positive value
		rows.push_back('{mk_beat(OP_WALL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 1, -1, -1, -1, -1, 1),
			1, mk_res(1 << 16, 599 << 16, 32'h7fff_ffff, 32'h7fff_ffff, -1, -1, -1, -1, 1'b1)});
		// largest disc exactly touching the walls is still inside
		rows.push_back('{mk_beat(OP_WALL, 255 << 16, 345 << 16, 1, 1, 255, 0, 0, 0, 0, 1),
			1, mk_res(255 << 16, 345 << 16, 1, 1, 0, 0, 0, 0, 1'b0)});
		// pair far apart at opposite extremes: untouched
		rows.push_back('{mk_beat(OP_PAIR, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 255, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 255),
			1, mk_res(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0)});
		// pair just out of reach along x
		rows.push_back('{mk_beat(OP_PAIR, 0, 0, 1 << 16, 0, 3, 5 << 16, 0, -(1 << 16), 0, 2),
			1, mk_res(0, 0, 1 << 16, 0, 5 << 16, 0, -(1 << 16), 0, 1'b0)});
		// overlapping, approaching head-on
		rows.push_back('{mk_beat(OP_PAIR, 100 << 16, 100 << 16, 2 << 16, 0, 10, 115 << 16,
			100 << 16, -(2 << 16), 0, 10), 0, none});
		// overlapping but separating: push apart only
		rows.push_back('{mk_beat(OP_PAIR, 100 << 16, 100 << 16, -(2 << 16), 1, 10, 112 << 16,
			104 << 16, 3 << 16, 5, 20), 0, none});
		// coincident centres take the fallback normal
		rows.push_back('{mk_beat(OP_PAIR, 50 << 16, 60 << 16, 1 << 16, 1 << 16, 7, 50 << 16,
			60 << 16, 0, 0, 9), 0, none});
		// centres a hair apart, still under the near-zero threshold
		rows.push_back('{mk_beat(OP_PAIR, 50 << 16, 60 << 16, 0, 0, 255, (50 << 16) + 1,
			60 << 16, -(1 << 20), 0, 255), 0, none});
		// deep overlap of the largest discs with extreme velocities: saturation
		rows.push_back('{mk_beat(OP_PAIR, 32'h7fff_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 255, 32'h7ffe_0000, 32'h8001_0000, 32'h8000_0000, 32'h8000_0000, 255),
			0, none});
		// unequal masses, diagonal contact
		rows.push_back('{mk_beat(OP_PAIR, 10 << 16, 10 << 16, 3 << 16, 3 << 16, 1, 12 << 16,
			11 << 16, -(1 << 16), 0, 255), 0, none});
		rows.push_back('{mk_beat(OP_PAIR, 300 << 16, 300 << 16, 0, -(1 << 16), 40, 290 << 16,
			330 << 16, 0, 1 << 16, 1), 0, none});
		foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].res);

		// random phases across screen settings; the first runs at the reset setting
		setting_w = '{16'd800, 16'd1, 16'd65535, 16'($urandom_range(1, 65535))};
		setting_h = '{16'd600, 16'd1, 16'd65535, 16'($urandom_range(1, 65535))};
		per_phase = 335;
		for (int ph = 0; ph < 4; ph++) begin
			if (ph != 0) begin
				drain_pipeline();
				write_screen(setting_w[ph], setting_h[ph]);
			end
			for (int n = 0; n < per_phase; n++) begin
				if (ph == 0 && n == 100) long_hold_req = 1'b1;
				send_beat(random_beat(screen_w, screen_h), 0, none);
			end
		end
		req.valid = 1'b0;

		// wait out the tail, bounded
		for (int c = 0; c < 20000 && pending_results.size() != 0; c++) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			errors += pending_results.size();
		end
		$display("covered %0d beats (%0d pair steps), %0d results checked, %0d touched",
			beats_sent, pair_count, beats_checked, touch_count);
		$display("screen settings 800x600, 1x1, 65535x65535 and %0dx%0d; %0d mismatches",
			setting_w[3], setting_h[3], errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
